@@ hdl/bsoc_pkg.sv @@
// Shared widths, constants and the cell voltage table for the SOC estimator.
`timescale 1ns / 1ps

package bsoc_pkg;

  // Field widths
  localparam int MV_W    = 20;
  localparam int CELLS_W = 8;
  localparam int UV_W    = 30;  // floor(1048575 * 1000) still fits
  localparam int SOC_W   = 7;
  localparam int COLOR_W = 8;

  // Table geometry
  localparam int TABLE_POINTS = 21;
  localparam int IDX_W        = $clog2(TABLE_POINTS);
  localparam int SOC_STEP     = 5;   // percent between neighboring points
  localparam int STEP_W       = $clog2(SOC_STEP + 1);
  localparam int X_W          = 18;  // widest segment spans 150000 uV
  localparam int CMP_W        = 22;  // 2 * SOC_STEP * span plus span

  // Arithmetic constants
  localparam logic [CELLS_W-1:0] CELLS_RESET = CELLS_W'(140);
  localparam int                 MV_TO_UV    = 1000;
  localparam int                 DIV_STEP    = 3;  // quotient bits per divider stage
  localparam logic [SOC_W-1:0]   SOC_FULL    = SOC_W'(100);
  localparam logic [SOC_W-1:0]   SOC_EMPTY   = SOC_W'(0);
  localparam logic [COLOR_W-1:0] COLOR_MAX   = COLOR_W'(255);

  // floor(soc * 255 / 100) == (soc * 255 * 5243) >> 19 for soc in 0..100
  localparam int GREEN_MUL   = 255 * 5243;
  localparam int GREEN_SHIFT = 19;
  localparam int GREEN_W     = 28;

  // Cell voltage of each table point in microvolts, highest first
  function automatic logic [UV_W-1:0] point_uv(input logic [IDX_W-1:0] idx);
    logic [UV_W-1:0] v;
    case (idx)
      IDX_W'(0):  v = UV_W'(4100000);
      IDX_W'(1):  v = UV_W'(4000000);
      IDX_W'(2):  v = UV_W'(3970000);
      IDX_W'(3):  v = UV_W'(3950000);
      IDX_W'(4):  v = UV_W'(3920000);
      IDX_W'(5):  v = UV_W'(3850000);
      IDX_W'(6):  v = UV_W'(3810000);
      IDX_W'(7):  v = UV_W'(3770000);
      IDX_W'(8):  v = UV_W'(3730000);
      IDX_W'(9):  v = UV_W'(3700000);
      IDX_W'(10): v = UV_W'(3640000);
      IDX_W'(11): v = UV_W'(3600000);
      IDX_W'(12): v = UV_W'(3550000);
      IDX_W'(13): v = UV_W'(3500000);
      IDX_W'(14): v = UV_W'(3450000);
      IDX_W'(15): v = UV_W'(3400000);
      IDX_W'(16): v = UV_W'(3340000);
      IDX_W'(17): v = UV_W'(3250000);
      IDX_W'(18): v = UV_W'(3100000);
      IDX_W'(19): v = UV_W'(2950000);
      IDX_W'(20): v = UV_W'(2800000);
      default:    v = '0;
    endcase
    return v;
  endfunction

  // State of charge of each table point
  function automatic logic [SOC_W-1:0] point_soc(input logic [IDX_W-1:0] idx);
    logic [SOC_W-1:0] s;
    case (idx)
      IDX_W'(0):  s = SOC_W'(100);
      IDX_W'(1):  s = SOC_W'(95);
      IDX_W'(2):  s = SOC_W'(90);
      IDX_W'(3):  s = SOC_W'(85);
      IDX_W'(4):  s = SOC_W'(80);
      IDX_W'(5):  s = SOC_W'(75);
      IDX_W'(6):  s = SOC_W'(70);
      IDX_W'(7):  s = SOC_W'(65);
      IDX_W'(8):  s = SOC_W'(60);
      IDX_W'(9):  s = SOC_W'(55);
      IDX_W'(10): s = SOC_W'(50);
      IDX_W'(11): s = SOC_W'(45);
      IDX_W'(12): s = SOC_W'(40);
      IDX_W'(13): s = SOC_W'(35);
      IDX_W'(14): s = SOC_W'(30);
      IDX_W'(15): s = SOC_W'(25);
      IDX_W'(16): s = SOC_W'(20);
      IDX_W'(17): s = SOC_W'(15);
      IDX_W'(18): s = SOC_W'(10);
      IDX_W'(19): s = SOC_W'(5);
      IDX_W'(20): s = SOC_W'(0);
      default:    s = '0;
    endcase
    return s;
  endfunction

endpackage

@@ hdl/bsoc_div.sv @@
// Pipelined restoring divider: a few quotient bits per stage, one transaction per cycle while out_ready holds.
`timescale 1ns / 1ps

module bsoc_div
  import bsoc_pkg::*;
#(
  parameter int NUM_W = UV_W,
  parameter int DEN_W = CELLS_W,
  parameter int STEP  = DIV_STEP
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [NUM_W-1:0] out_quo
);

  localparam int STAGES = (NUM_W + STEP - 1) / STEP;
  localparam int PAD_W  = STAGES * STEP;

  logic             vld   [STAGES];
  logic [PAD_W-1:0] num_r [STAGES];
  logic [PAD_W-1:0] quo_r [STAGES];
  logic [DEN_W-1:0] rem_r [STAGES];
  logic [DEN_W-1:0] den_r [STAGES];
  logic [STAGES:0]  rdy;

  // Backpressure: a stage takes new data when empty or when it drains
  always_comb begin
    rdy[STAGES] = out_ready;
    for (int s = STAGES - 1; s >= 0; s--) begin
      rdy[s] = !vld[s] || rdy[s+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[STAGES-1];
  assign out_quo   = quo_r[STAGES-1][NUM_W-1:0];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic             src_v;
    logic [PAD_W-1:0] src_num;
    logic [PAD_W-1:0] src_quo;
    logic [DEN_W-1:0] src_rem;
    logic [DEN_W-1:0] src_den;
    logic [PAD_W-1:0] num_next;
    logic [PAD_W-1:0] quo_next;
    logic [DEN_W-1:0] rem_next;

    if (s == 0) begin : g_first
      // leading zero padding only adds leading zero quotient bits
      assign src_v   = in_valid;
      assign src_num = PAD_W'(in_num);
      assign src_quo = '0;
      assign src_rem = '0;
      assign src_den = in_den;
    end else begin : g_rest
      assign src_v   = vld[s-1];
      assign src_num = num_r[s-1];
      assign src_quo = quo_r[s-1];
      assign src_rem = rem_r[s-1];
      assign src_den = den_r[s-1];
    end

    // STEP shift-and-subtract steps on narrow values
    always_comb begin
      logic [DEN_W:0] trial;
      num_next = src_num;
      quo_next = src_quo;
      rem_next = src_rem;
      for (int b = 0; b < STEP; b++) begin
        trial = {rem_next, num_next[PAD_W-1]};
        if (trial >= {1'b0, src_den}) begin
          rem_next = DEN_W'(trial - {1'b0, src_den});
          quo_next = {quo_next[PAD_W-2:0], 1'b1};
        end else begin
          rem_next = trial[DEN_W-1:0];
          quo_next = {quo_next[PAD_W-2:0], 1'b0};
        end
        num_next = {num_next[PAD_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s+1] || !vld[s]) begin
        vld[s] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && src_v) begin
        num_r[s] <= num_next;
        quo_r[s] <= quo_next;
        rem_r[s] <= rem_next;
        den_r[s] <= src_den;
      end
    end
  end

endmodule

@@ hdl/battery_soc_from_voltage.sv @@
// Top level: pack voltage to state of charge and bar color, fully pipelined.
`timescale 1ns / 1ps

// Takes one pack voltage sample per cycle and returns one result per sample,
// in order. One stage scales millivolts to microvolts, ten divider stages
// (3 quotient bits each, set by DIV_BITS) divide by the series cell count,
// then four stages find the table segment, take the offset into it,
// interpolate with round half up, and form the bar colors. Sustained rate
// is one transaction per clock whenever the output side takes results; any
// empty stage absorbs a new sample during a stall. cells_in_series resets
// to 140, a value of 0 acts as 1, and it should only be written while no
// transaction is in flight.

module battery_soc_from_voltage
  import bsoc_pkg::*;
#(
  parameter int DIV_BITS = DIV_STEP
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [CELLS_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MV_W-1:0]    pack_millivolts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SOC_W-1:0]   soc_percent,
  output logic [COLOR_W-1:0] bar_red,
  output logic [COLOR_W-1:0] bar_green
);

  // Config register
  logic [CELLS_W-1:0] cells_in_series;
  logic [CELLS_W-1:0] cells_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_in_series <= CELLS_RESET;
    end else if (cfg_wr_en) begin
      cells_in_series <= cfg_wr_data;
    end
  end

  assign cells_eff = (cells_in_series == '0) ? CELLS_W'(1) : cells_in_series;

  // Handshake chain, output end first
  logic a_valid, b_valid, c_valid, d_valid, e_valid;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
  logic div_in_ready, div_out_valid;
  logic [UV_W-1:0] div_quo;

  assign rdy_e    = !e_valid || out_ready;
  assign rdy_d    = !d_valid || rdy_e;
  assign rdy_c    = !c_valid || rdy_d;
  assign rdy_b    = !b_valid || rdy_c;
  assign rdy_a    = !a_valid || div_in_ready;
  assign in_ready = rdy_a;

  // Stage A: millivolts times 1000
  logic [UV_W-1:0] a_uv_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (rdy_a) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      a_uv_num <= UV_W'(pack_millivolts) * UV_W'(MV_TO_UV);
    end
  end

  // Divide by the cell count
  bsoc_div #(
    .NUM_W (UV_W),
    .DEN_W (CELLS_W),
    .STEP  (DIV_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_ready  (div_in_ready),
    .in_num    (a_uv_num),
    .in_den    (cells_eff),
    .out_valid (div_out_valid),
    .out_ready (rdy_b),
    .out_quo   (div_quo)
  );

  // Stage B: segment search against all table points
  logic [IDX_W-1:0]        seg_next;
  logic [TABLE_POINTS-1:0] above_pt;
  logic [IDX_W-1:0]        b_seg;
  logic                    b_above, b_below;
  logic [UV_W-1:0]         b_uv;

  always_comb begin
    for (int j = 0; j < TABLE_POINTS; j++) begin
      above_pt[j] = div_quo > point_uv(IDX_W'(j));
    end
    // highest point exceeded (lowest index) marks the segment just above it
    seg_next = '0;
    for (int j = TABLE_POINTS - 1; j >= 1; j--) begin
      if (above_pt[j]) begin
        seg_next = IDX_W'(j - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (rdy_b) begin
      b_valid <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && div_out_valid) begin
      b_seg   <= seg_next;
      b_above <= above_pt[0];
      b_below <= !above_pt[TABLE_POINTS-1];
      b_uv    <= div_quo;
    end
  end

  // Stage C: offset into segment and segment span
  logic [UV_W-1:0]  seg_low_uv;
  logic [X_W-1:0]   c_x, c_span;
  logic [SOC_W-1:0] c_soc_low;
  logic             c_above, c_below;

  assign seg_low_uv = point_uv(b_seg + IDX_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (rdy_c) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && b_valid) begin
      c_x       <= X_W'(b_uv - seg_low_uv);
      c_span    <= X_W'(point_uv(b_seg) - seg_low_uv);
      c_soc_low <= point_soc(b_seg + IDX_W'(1));
      c_above   <= b_above;
      c_below   <= b_below;
    end
  end

  // Stage D: interpolate, round half up
  // quotient of (2*step*x + span) / (2*span) counted against its few thresholds
  logic [CMP_W-1:0]  interp_num;
  logic [STEP_W-1:0] interp_q;
  logic [SOC_W-1:0]  soc_next;
  logic [SOC_W-1:0]  d_soc;

  always_comb begin
    interp_num = CMP_W'(c_x) * CMP_W'(2 * SOC_STEP) + CMP_W'(c_span);
    interp_q   = '0;
    for (int k = 1; k <= SOC_STEP; k++) begin
      if (interp_num >= CMP_W'(2 * k) * CMP_W'(c_span)) begin
        interp_q = interp_q + STEP_W'(1);
      end
    end
    if (c_above) begin
      soc_next = SOC_FULL;
    end else if (c_below) begin
      soc_next = SOC_EMPTY;
    end else begin
      soc_next = c_soc_low + SOC_W'(interp_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (rdy_d) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d && c_valid) begin
      d_soc <= soc_next;
    end
  end

  // Stage E: bar colors, output register
  logic [GREEN_W-1:0] green_prod;
  logic [COLOR_W-1:0] green_next;
  logic [SOC_W-1:0]   e_soc;
  logic [COLOR_W-1:0] e_green;

  assign green_prod = GREEN_W'(d_soc) * GREEN_W'(GREEN_MUL);
  assign green_next = COLOR_W'(green_prod >> GREEN_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (rdy_e) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_e && d_valid) begin
      e_soc   <= d_soc;
      e_green <= green_next;
    end
  end

  assign out_valid   = e_valid;
  assign soc_percent = e_soc;
  assign bar_green   = e_green;
  assign bar_red     = COLOR_MAX - e_green;

endmodule

@@ hdl/bsoc_checker.sv @@
// Port-level checks on the SOC estimator and the bind that attaches them.
`timescale 1ns / 1ps

module bsoc_checker
  import bsoc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SOC_W-1:0]   soc_percent,
  input logic [COLOR_W-1:0] bar_red,
  input logic [COLOR_W-1:0] bar_green
);

  // A stalled result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(soc_percent)
      && $stable(bar_green) && $stable(bar_red))
    else $error("result changed or dropped while stalled");

  // Interpolation never leaves the table range
  a_soc_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> soc_percent <= SOC_FULL)
    else $error("soc_percent above full");

  // Red and green always split full intensity
  a_color_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, bar_red} + {1'b0, bar_green}) == {1'b0, COLOR_MAX})
    else $error("bar colors do not sum to full scale");

  // Full and empty charge map to the color end points
  a_color_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && (soc_percent == SOC_FULL || soc_percent == SOC_EMPTY) |->
      (soc_percent == SOC_FULL) == (bar_green == COLOR_MAX)
      && (soc_percent == SOC_EMPTY) == (bar_green == '0))
    else $error("bar color wrong at full or empty charge");

endmodule

bind battery_soc_from_voltage bsoc_checker u_bsoc_checker (.*);

@@ test/tb_battery_soc_from_voltage.sv @@
// Testbench for battery_soc_from_voltage: directed table plus random phases, checked in order.
`timescale 1ns / 1ps

module tb_battery_soc_from_voltage;
  import bsoc_pkg::*;

  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 200;
  localparam int ROWS         = 24;
  localparam int MV_MAX       = (1 << MV_W) - 1;

  typedef struct packed {
    logic [SOC_W-1:0]   soc;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
  } gauge_t;

  typedef struct packed {
    logic [CELLS_W-1:0] cells;
    logic [MV_W-1:0]    mv;
    logic               known;  // expected gauge typed in below
    gauge_t             want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [CELLS_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [MV_W-1:0]    pack_millivolts = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [SOC_W-1:0]   soc_percent;
  logic [COLOR_W-1:0] bar_red;
  logic [COLOR_W-1:0] bar_green;

  // Discharge curve: cell voltage in uV and charge in percent, highest first
  int unsigned knee_uv [TABLE_POINTS] = '{
    4100000, 4000000, 3970000, 3950000, 3920000, 3850000, 3810000,
    3770000, 3730000, 3700000, 3640000, 3600000, 3550000, 3500000,
    3450000, 3400000, 3340000, 3250000, 3100000, 2950000, 2800000};
  int unsigned knee_pct [TABLE_POINTS] = '{
    100, 95, 90, 85, 80, 75, 70, 65, 60, 55, 50,
    45, 40, 35, 30, 25, 20, 15, 10, 5, 0};

  // Directed sweep: extremes, knee points, rounding and cell-count corners
  row_t plan [ROWS] = '{
    '{8'd140, 20'd0,       1'b1, '{7'd0,   8'd255, 8'd0}},    // empty pack
    '{8'd140, 20'd1048575, 1'b1, '{7'd100, 8'd0,   8'd255}},  // full scale
    '{8'd140, 20'd574000,  1'b1, '{7'd100, 8'd0,   8'd255}},  // top knee, inclusive
    '{8'd140, 20'd574001,  1'b0, '0},                         // just above top knee
    '{8'd140, 20'd392000,  1'b1, '{7'd0,   8'd255, 8'd0}},    // bottom knee
    '{8'd140, 20'd392001,  1'b0, '0},                         // just above bottom knee
    '{8'd140, 20'd509600,  1'b1, '{7'd50,  8'd128, 8'd127}},  // mid knee exactly
    '{8'd140, 20'd561400,  1'b0, '0},                         // round half up
    '{8'd140, 20'd561399,  1'b0, '0},                         // just below the half
    '{8'd140, 20'd500000,  1'b0, '0},
    '{8'd1,   20'd4100,    1'b1, '{7'd100, 8'd0,   8'd255}},
    '{8'd1,   20'd4101,    1'b1, '{7'd100, 8'd0,   8'd255}},
    '{8'd1,   20'd2800,    1'b1, '{7'd0,   8'd255, 8'd0}},
    '{8'd1,   20'd2801,    1'b0, '0},
    '{8'd1,   20'd3700,    1'b0, '0},
    '{8'd1,   20'd3999,    1'b0, '0},
    '{8'd1,   20'd3175,    1'b0, '0},
    '{8'd1,   20'd1048575, 1'b1, '{7'd100, 8'd0,   8'd255}},
    '{8'd255, 20'd1048575, 1'b1, '{7'd100, 8'd0,   8'd255}},
    '{8'd255, 20'd1000000, 1'b0, '0},
    '{8'd255, 20'd0,       1'b1, '{7'd0,   8'd255, 8'd0}},
    '{8'd0,   20'd3640,    1'b1, '{7'd50,  8'd128, 8'd127}},  // zero count acts as one
    '{8'd0,   20'd4100,    1'b1, '{7'd100, 8'd0,   8'd255}},
    '{8'd0,   20'd0,       1'b1, '{7'd0,   8'd255, 8'd0}}
  };

  gauge_t             gauge_q [$];
  gauge_t             head;
  logic [CELLS_W-1:0] cells_now = CELLS_RESET;
  int                 errors = 0;
  int                 cycle_count = 0;
  int                 burst_left = 0;
  int                 rx_mode = 0;
  int                 rx_left = 0;

  battery_soc_from_voltage dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .pack_millivolts (pack_millivolts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .soc_percent     (soc_percent),
    .bar_red         (bar_red),
    .bar_green       (bar_green)
  );

  always #1 clk = ~clk;

  // Charge and bar colors for one pack sample at a given series cell count
  function automatic gauge_t predict_gauge(input logic [MV_W-1:0] mv,
                                           input logic [CELLS_W-1:0] cells);
    longint unsigned divisor, uv, hi, lo, span, num;
    int unsigned     pct, grn;
    gauge_t          g;
    divisor = (cells == '0) ? 1 : longint'(cells);
    uv      = (longint'(mv) * 1000) / divisor;
    pct     = 0;
    if (uv > knee_uv[0]) begin
      pct = knee_pct[0];
    end else begin
      for (int i = 0; i < TABLE_POINTS - 1; i++) begin
        hi = knee_uv[i];
        lo = knee_uv[i + 1];
        if (uv <= hi && uv > lo) begin
          span = hi - lo;
          num  = 2 * (uv - lo) * (knee_pct[i] - knee_pct[i + 1]) + span;
          pct  = knee_pct[i + 1] + int'(num / (2 * span));
        end
      end
    end
    grn     = pct * 255 / 100;
    g.soc   = SOC_W'(pct);
    g.green = COLOR_W'(grn);
    g.red   = COLOR_W'(255 - grn);
    return g;
  endfunction

  // Mostly cell voltages across the curve and near its knees, some raw noise
  function automatic logic [MV_W-1:0] pick_sample(input logic [CELLS_W-1:0] cells);
    longint unsigned n, uv, mv;
    int unsigned     roll, k;
    n    = (cells == '0) ? 1 : longint'(cells);
    roll = $urandom_range(0, 99);
    if (roll < 20) return MV_W'($urandom_range(0, MV_MAX));
    if (roll < 45) begin
      k  = $urandom_range(0, TABLE_POINTS - 1);
      uv = knee_uv[k] + $urandom_range(0, 4000) - 2000;
    end else begin
      uv = $urandom_range(2750000, 4150000);
    end
    mv = (uv * n) / 1000 + $urandom_range(0, 1);
    if (mv > MV_MAX) mv = MV_MAX;
    return MV_W'(mv);
  endfunction

  // Present one sample and hold it until the transaction completes
  task automatic send_sample(input logic [MV_W-1:0] mv, input gauge_t want);
    in_valid        <= 1'b1;
    pack_millivolts <= mv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gauge_q.push_back(want);
  endtask

  // Send, then maybe idle at the end of a burst
  task automatic feed(input logic [MV_W-1:0] mv, input gauge_t want);
    int gap;
    send_sample(mv, want);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (gauge_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cells(input logic [CELLS_W-1:0] cells);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cells;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cells_now    = cells;
  endtask

  // Receiver: stall modes picked at random, each held for a random length
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 9) < 7);
      end
      2: begin
        out_ready <= ($urandom_range(0, 9) < 3);
      end
      default: begin
        out_ready <= rx_left[3];
      end
    endcase
  end

  // Result checker: in order against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (gauge_q.size() == 0) begin
        $error("unexpected transaction: soc_percent %0d bar_red %0d bar_green %0d",
               soc_percent, bar_red, bar_green);
        errors++;
      end else begin
        head = gauge_q.pop_front();
        if (soc_percent !== head.soc) begin
          $error("soc_percent: expected %0d, got %0d", head.soc, soc_percent);
          errors++;
        end
        if (bar_red !== head.red) begin
          $error("bar_red: expected %0d, got %0d", head.red, bar_red);
          errors++;
        end
        if (bar_green !== head.green) begin
          $error("bar_green: expected %0d, got %0d", head.green, bar_green);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("battery_soc_from_voltage test failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    logic [CELLS_W-1:0] phase_cells [PHASES];
    logic [MV_W-1:0]    mv;
    gauge_t             want;
    phase_cells = '{8'd1, 8'd255, 8'd0, 8'd140, 8'd2, 8'd0, 8'd0, 8'd200};
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed table; the first rows run on the reset cell count
    for (int r = 0; r < ROWS; r++) begin
      if (plan[r].cells != cells_now) begin
        wait_for_results();
        write_cells(plan[r].cells);
      end
      want = plan[r].known ? plan[r].want : predict_gauge(plan[r].mv, cells_now);
      feed(plan[r].mv, want);
    end

    // Random phases, each on its own cell count
    for (int p = 0; p < PHASES; p++) begin
      wait_for_results();
      if (p == 5 || p == 6)
        write_cells(CELLS_W'($urandom_range(1, 255)));
      else
        write_cells(phase_cells[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        mv = pick_sample(cells_now);
        feed(mv, predict_gauge(mv, cells_now));
      end
    end

    wait_for_results();
    if (errors == 0)
      $display("battery_soc_from_voltage test passed");
    else
      $display("battery_soc_from_voltage test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/bsoc_pkg.sv
hdl/bsoc_div.sv
hdl/battery_soc_from_voltage.sv
hdl/bsoc_checker.sv
test/tb_battery_soc_from_voltage.sv
